FILE: rtl/core/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants for the sliding window maximum unit.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int QDEPTH   = 64;
  localparam int SAMPLE_W = 32;
  localparam int POS_W    = 7;
  localparam int CNT_W    = 7;
  localparam int WS_W     = 7;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [CNT_W-1:0] QDEPTH_C  = CNT_W'(QDEPTH);
  localparam logic [WS_W-1:0]  WS_RESET  = WS_W'(1);

  // register index, taken from the word address bit
  localparam logic REG_WINDOW_SIZE = 1'b0;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic [POS_W-1:0]           pos;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SH1,
    CELL_SH2,
    CELL_LOAD
  } cell_op_t;

endpackage

FILE: rtl/core/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell
// One queue slot: holds an entry, compares it against the incoming sample,
// and takes its next entry from itself, a neighbor or the new sample.
// ----------------------------------------------------------------------------
module swm_cell (
  input  logic                                clk,
  input  swm_pkg::cell_op_t                   op,
  input  logic                                occ,
  input  logic signed [swm_pkg::SAMPLE_W-1:0] sample,
  input  swm_pkg::entry_t                     right1,
  input  swm_pkg::entry_t                     right2,
  input  swm_pkg::entry_t                     new_entry,
  output swm_pkg::entry_t                     entry_o,
  output logic                                gt_o
);

  swm_pkg::entry_t entry_r;
  swm_pkg::entry_t entry_nxt;

  always_comb begin
    case (op)
      swm_pkg::CELL_HOLD: entry_nxt = entry_r;
      swm_pkg::CELL_SH1:  entry_nxt = right1;
      swm_pkg::CELL_SH2:  entry_nxt = right2;
      swm_pkg::CELL_LOAD: entry_nxt = new_entry;
      default:            entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  // survives the back pop only if strictly greater
  assign gt_o    = occ && (entry_r.value > sample);
  assign entry_o = entry_r;

endmodule

FILE: rtl/core/sliding_window_max_monotonic_deque_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_max_monotonic_deque_unit
// Sliding window maximum over signed samples, kept in a monotonic decreasing
// queue held by a row of compare cells with the front at cell 0.
// ----------------------------------------------------------------------------
//  channel | ports                              | direction
//  in      | in_valid in_stall in_sample        | item in
//          | in_start_req                       |
//  out     | out_valid out_stall out_window_max | item out
//  cfg     | psel penable pwrite paddr pwdata   | register access
//          | prdata pready                      |
//
//  One item per cycle: all cells compare against the sample in parallel and
//  the queue shifts by up to two slots in the same cycle.
//  Results sit in one output register; a new item is taken while that
//  register is empty or being taken in the same cycle.
//  Reset empties the queue; window_size resets to 1.
// ----------------------------------------------------------------------------
module sliding_window_max_monotonic_deque_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [swm_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                in_start_req,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [swm_pkg::SAMPLE_W-1:0] out_window_max,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swm_pkg::ADDR_W-1:0]          paddr,
  input  logic [swm_pkg::DATA_W-1:0]          pwdata,
  output logic [swm_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  localparam int QD = swm_pkg::QDEPTH;
  localparam int CW = swm_pkg::CNT_W;

  logic [swm_pkg::WS_W-1:0]  ws_r;
  logic [CW-1:0]             count_r, count_nxt;
  logic [CW-1:0]             fill_r, fill_nxt;
  logic [swm_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic                      out_valid_r;
  logic signed [swm_pkg::SAMPLE_W-1:0] out_max_r;

  logic                      in_acc;
  logic [CW-1:0]             cnt_eff, fill_eff, k, w;
  logic [swm_pkg::POS_W-1:0] pos_eff, age;
  logic [CW:0]               fill_inc;
  logic                      d0, d1, emit;
  logic [1:0]                d;
  logic [QD-1:0]             gt, trans, occ;
  swm_pkg::entry_t           new_entry, front;
  swm_pkg::entry_t           cell_q [QD];
  swm_pkg::cell_op_t         cell_op [QD];

  // configuration
  assign pready = 1'b1;
  assign prdata = {{(swm_pkg::DATA_W-swm_pkg::WS_W){1'b0}}, ws_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r <= swm_pkg::WS_RESET;
    end else if (psel && penable && pwrite && paddr[2] == swm_pkg::REG_WINDOW_SIZE) begin
      ws_r <= pwdata[swm_pkg::WS_W-1:0];
    end
  end

  always_comb begin
    if (ws_r == '0) begin
      w = CW'(1);
    end else if (ws_r > swm_pkg::QDEPTH_C) begin
      w = swm_pkg::QDEPTH_C;
    end else begin
      w = ws_r;
    end
  end

  // handshake
  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_window_max = out_max_r;

  assign cnt_eff  = in_start_req ? '0 : count_r;
  assign fill_eff = in_start_req ? '0 : fill_r;
  assign pos_eff  = in_start_req ? '0 : pos_r;
  assign new_entry.value = in_sample;
  assign new_entry.pos   = pos_eff;

  // cell row
  for (genvar i = 0; i < QD; i++) begin : g_cell
    assign occ[i] = (CW'(i) < cnt_eff);
    swm_cell u_cell (
      .clk       (clk),
      .op        (cell_op[i]),
      .occ       (occ[i]),
      .sample    (in_sample),
      .right1    ((i + 1 < QD) ? cell_q[(i + 1) % QD] : new_entry),
      .right2    ((i + 2 < QD) ? cell_q[(i + 2) % QD] : new_entry),
      .new_entry (new_entry),
      .entry_o   (cell_q[i]),
      .gt_o      (gt[i])
    );
  end

  // survivors form a prefix; find its length
  always_comb begin
    for (int i = 0; i < QD; i++) begin
      if (i == QD - 1) begin
        trans[i] = gt[i];
      end else begin
        trans[i] = gt[i] && !gt[(i + 1) % QD];
      end
    end
  end

  always_comb begin
    k = '0;
    for (int i = 0; i < QD; i++) begin
      if (trans[i]) begin
        k = k | CW'(i + 1);
      end
    end
  end

  // full queue drops its front before the append
  assign d0 = (k == swm_pkg::QDEPTH_C);

  always_comb begin
    if (d0) begin
      front = cell_q[1];
    end else if (k == '0) begin
      front = new_entry;
    end else begin
      front = cell_q[0];
    end
  end

  assign fill_inc = {1'b0, fill_eff} + (CW+1)'(1);
  assign fill_nxt = (fill_inc >= {1'b0, w}) ? w : fill_inc[CW-1:0];
  assign emit     = (fill_nxt == w);
  assign age      = pos_eff - front.pos;
  assign d1       = emit && (age >= (w - CW'(1)));
  assign d        = {1'b0, d0} + {1'b0, d1};
  assign count_nxt = k + CW'(1) - CW'(d);
  assign pos_nxt  = pos_eff + swm_pkg::POS_W'(1);

  always_comb begin
    logic [CW:0] idx;
    for (int i = 0; i < QD; i++) begin
      idx = (CW+1)'(i) + (CW+1)'(d);
      if (!in_acc) begin
        cell_op[i] = swm_pkg::CELL_HOLD;
      end else if (idx < {1'b0, k}) begin
        case (d)
          2'd0:    cell_op[i] = swm_pkg::CELL_HOLD;
          2'd1:    cell_op[i] = swm_pkg::CELL_SH1;
          2'd2:    cell_op[i] = swm_pkg::CELL_SH2;
          default: cell_op[i] = swm_pkg::CELL_HOLD;
        endcase
      end else if (idx == {1'b0, k}) begin
        cell_op[i] = swm_pkg::CELL_LOAD;
      end else begin
        cell_op[i] = swm_pkg::CELL_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      fill_r      <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        count_r     <= count_nxt;
        fill_r      <= fill_nxt;
        pos_r       <= pos_nxt;
        out_valid_r <= emit;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_max_r <= front.value;
    end
  end

  ap_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= swm_pkg::QDEPTH_C)
    else $error("queue count above depth");

  ap_survivor_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((gt + {{(QD-1){1'b0}}, 1'b1}) & gt) == '0)
    else $error("surviving entries not a prefix");

  ap_start_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_start_req |=> fill_r == CW'(1))
    else $error("start did not restart fill");

  ap_count_growth: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> count_r <= $past(cnt_eff) + CW'(1))
    else $error("queue grew by more than one");

  ap_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(count_r) && $stable(fill_r))
    else $error("queue state changed without an item");

endmodule

FILE: tb/swm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_checker
// Watches the sample, result and register ports of the sliding window maximum
// unit. Keeps its own monotonic queue and window setting, works out the
// window maximum each accepted item should yield, and compares every accepted
// result against the oldest one still waiting.
// ----------------------------------------------------------------------------
module swm_checker
  import swm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_start_req,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [SAMPLE_W-1:0] out_window_max,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output int                         errors = 0,
  output int                         pending = 0
);

  localparam int EXP_DEPTH = 16;

  logic signed [SAMPLE_W-1:0] dq_value [QDEPTH];
  logic [POS_W-1:0]           dq_pos   [QDEPTH];
  int                         dq_head;
  int                         dq_count;
  int                         fill;
  logic [POS_W-1:0]           next_pos;
  logic [WS_W-1:0]            win_size;

  logic signed [SAMPLE_W-1:0] exp_ring [EXP_DEPTH];
  int                         exp_rd = 0;
  int                         exp_wr = 0;

  task automatic report_mismatch(input string what, input logic signed [SAMPLE_W-1:0] got,
                                 input logic signed [SAMPLE_W-1:0] want);
    $display("%0t: %s: got %0d, want %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic drop_front();
    dq_head  = (dq_head + 1) % QDEPTH;
    dq_count = dq_count - 1;
  endtask

  task automatic advance_window(input logic signed [SAMPLE_W-1:0] s, input logic st,
                                output bit has_max, output logic signed [SAMPLE_W-1:0] mx);
    int               w;
    int               tail;
    int               age;
    logic [POS_W-1:0] p;
    w = (win_size == 0) ? 1 : ((win_size > QDEPTH) ? QDEPTH : int'(win_size));
    if (st) begin
      dq_head  = 0;
      dq_count = 0;
      fill     = 0;
      next_pos = '0;
    end
    p = next_pos;
    // pop from the back everything not larger than the new sample
    while (dq_count > 0) begin
      tail = (dq_head + dq_count - 1) % QDEPTH;
      if (dq_value[tail] <= s) dq_count = dq_count - 1;
      else break;
    end
    if (dq_count >= QDEPTH) drop_front();
    tail           = (dq_head + dq_count) % QDEPTH;
    dq_value[tail] = s;
    dq_pos[tail]   = p;
    dq_count       = dq_count + 1;
    next_pos       = p + 1'b1;
    fill           = (fill + 1 >= w) ? w : fill + 1;
    has_max        = (fill == w);
    mx             = dq_value[dq_head];
    if (has_max) begin
      age = (int'(p) - int'(dq_pos[dq_head])) & 127;
      if (age >= w - 1) drop_front();
    end
  endtask

  always @(posedge clk) begin
    bit                         has_max;
    logic signed [SAMPLE_W-1:0] mx;
    logic signed [SAMPLE_W-1:0] want;
    if (!rst_n) begin
      dq_head  = 0;
      dq_count = 0;
      fill     = 0;
      next_pos = '0;
      win_size = WS_RESET;
      exp_rd   = 0;
      exp_wr   = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (exp_wr == exp_rd) begin
          report_mismatch("result with nothing expected", out_window_max, '0);
        end else begin
          want   = exp_ring[exp_rd % EXP_DEPTH];
          exp_rd = exp_rd + 1;
          if (out_window_max !== want) report_mismatch("window_max", out_window_max, want);
        end
      end
      if (in_valid && !in_stall) begin
        advance_window(in_sample, in_start_req, has_max, mx);
        if (has_max) begin
          exp_ring[exp_wr % EXP_DEPTH] = mx;
          exp_wr = exp_wr + 1;
        end
      end
      if (psel && penable && pwrite && pready && paddr[2] == REG_WINDOW_SIZE)
        win_size = pwdata[WS_W-1:0];
    end
    pending <= exp_wr - exp_rd;
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the sliding window maximum unit: a directed pass over extreme
// samples, equal values, start requests and odd window sizes, then random
// sequences under changing window sizes, including runs that fill the queue.
// Input is sent in bursts with gaps; the result side stalls in varying
// patterns. The checker instance does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb;
  import swm_pkg::*;

  localparam int NUM_ITEMS   = 1650;
  localparam int DRAIN_LIMIT = 20000;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       in_start_req;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_window_max;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [ADDR_W-1:0]          paddr;
  logic [DATA_W-1:0]          pwdata;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;

  int errors;
  int pending;

  int items_sent = 0;
  int burst_left = 1;
  bit vld_on     = 1'b0;
  int full_runs  = 0;

  int       stall_mode = 0;
  int       stall_left = 0;
  bit [7:0] stall_pat  = 8'h00;

  sliding_window_max_monotonic_deque_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .in_start_req   (in_start_req),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_window_max (out_window_max),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  swm_checker CHK (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .in_start_req   (in_start_req),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_window_max (out_window_max),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .errors         (errors),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb failed");
    $finish;
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
      stall_pat  = 8'($urandom);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= ($urandom_range(0, 9) < 7);
      default: begin
        out_stall <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[7:1]};
      end
    endcase
  end

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $signed($urandom_range(0, 15)) - 8;
      7:          return 32'sh7fffffff;
      8:          return 32'sh80000000;
      default:    return $urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, 3)
                                              : 32'sh80000000 + $urandom_range(0, 3);
    endcase
  endfunction

  function automatic logic [WS_W-1:0] pick_window();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return WS_W'(1);
      2:       return WS_W'(QDEPTH);
      3:       return WS_W'($urandom_range(QDEPTH + 1, 127));
      4, 5:    return WS_W'($urandom_range(9, QDEPTH));
      default: return WS_W'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic push_item(input logic signed [SAMPLE_W-1:0] s, input logic st);
    bit ok;
    in_valid     <= 1'b1;
    in_sample    <= s;
    in_start_req <= st;
    vld_on = 1'b1;
    do begin
      @(negedge clk);
      ok = !in_stall;
      @(posedge clk);
    end while (!ok);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      vld_on = 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 24);
    end
  endtask

  task automatic settle();
    if (vld_on) begin
      in_valid <= 1'b0;
      vld_on = 1'b0;
    end
    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_window(input logic [WS_W-1:0] ws);
    bit          ok;
    logic [31:0] word;
    settle();
    word = $urandom;
    word[WS_W-1:0] = ws;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_WINDOW_SIZE, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      ok = pready;
      @(posedge clk);
    end while (!ok);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // grow the queue to its full depth, then append twice more
  task automatic fill_queue();
    logic signed [SAMPLE_W-1:0] v;
    v = 32'sh7fff0000 + $urandom_range(0, 65535);
    write_window(WS_W'(QDEPTH));
    push_item(v, 1'b1);
    repeat (QDEPTH - 2) begin
      v = v - $urandom_range(1, 5000);
      push_item(v, 1'b0);
    end
    write_window(WS_W'(2));
    v = v - $urandom_range(1, 5000);
    push_item(v, 1'b0);
    write_window(WS_W'(QDEPTH));
    repeat (3) begin
      v = v - $urandom_range(1, 5000);
      push_item(v, 1'b0);
    end
  endtask

  initial begin
    int n;
    bit first_start;
    int drain;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample    = '0;
    in_start_req = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset window size, sequence begun without a start request
    push_item(32'sd0, 1'b0);
    push_item(32'sh7fffffff, 1'b0);
    push_item(32'sh80000000, 1'b0);
    push_item(-32'sd1, 1'b0);
    push_item(32'sd5, 1'b0);
    push_item(32'sd5, 1'b0);

    write_window(WS_W'(3));
    push_item(32'sd10, 1'b1);
    push_item(32'sd20, 1'b0);
    push_item(32'sd20, 1'b0);
    push_item(-32'sd7, 1'b0);
    push_item(32'sh80000000, 1'b0);
    push_item(32'sh7fffffff, 1'b0);
    push_item(32'sd3, 1'b0);
    push_item(32'sd3, 1'b0);

    // size zero, changed inside the running sequence
    write_window('0);
    push_item(32'sd1, 1'b0);
    push_item(32'sd2, 1'b0);

    // above the depth limit
    write_window(WS_W'(127));
    push_item(32'sh7fffffff, 1'b1);
    push_item(32'sd100, 1'b0);
    push_item(-32'sd100, 1'b0);
    push_item(32'sh80000000, 1'b0);

    write_window(WS_W'(QDEPTH));
    push_item(32'sd9, 1'b0);
    push_item(32'sd9, 1'b0);

    while (items_sent < NUM_ITEMS) begin
      if ($urandom_range(0, 19) == 0 && full_runs < 3) begin
        full_runs++;
        fill_queue();
      end else begin
        write_window(pick_window());
        n           = $urandom_range(8, 60);
        first_start = ($urandom_range(0, 4) != 0);
        for (int i = 0; i < n; i++)
          push_item(rand_sample(), (i == 0) ? first_start : ($urandom_range(0, 29) == 0));
      end
    end

    if (vld_on) begin
      in_valid <= 1'b0;
      vld_on = 1'b0;
    end
    drain = 0;
    do begin
      @(negedge clk);
      drain++;
    end while (pending != 0 && drain < DRAIN_LIMIT);
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
